// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
// Depends on nothing; every use gives its own clock, and BPMS_ASSERT also its reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define BPMS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define BPMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/bpms_pkg.sv =====
// Shared types and constants of the PDEP / MULX / SHRX execution unit.
// Depends on nothing; every module of the block imports it.
package bpms_pkg;

  // Operand and result geometry.
  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int GROUP_W = 8;
  localparam int GROUPS  = WORD_W / GROUP_W;
  localparam int CNT_W   = $clog2(WORD_W);

  // Operation codes.
  localparam logic [1:0] OP_PDEP = 2'd0;
  localparam logic [1:0] OP_MULX = 2'd1;
  localparam logic [1:0] OP_SHRX = 2'd2;

  // Shift count masks for the two operand sizes.
  localparam logic [CNT_W-1:0] SHIFT_MASK_WIDE   = 6'h3f;
  localparam logic [CNT_W-1:0] SHIFT_MASK_NARROW = 6'h1f;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [2*WORD_W-1:0] dword_t;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       wide;
  } ctrl_t;

endpackage

// ===== hdl/bpms_deposit.sv =====
// Bit deposit datapath: two register stages of rank computation and a final select.
// Depends on bpms_pkg.
module bpms_deposit import bpms_pkg::*; (
  input  logic  clk,
  input  word_t mask,
  input  word_t src,
  output word_t result
);

  word_t      mask_s2;
  word_t      src_s2;
  logic [2:0] local_s2 [WORD_W];
  logic [3:0] count_s2 [GROUPS];

  word_t      mask_s3;
  word_t      src_s3;
  logic [2:0] local_s3 [WORD_W];
  logic [5:0] offset_s3 [GROUPS];

  logic [2:0] local_next  [WORD_W];
  logic [3:0] count_next  [GROUPS];
  logic [5:0] offset_next [GROUPS];

  // Rank of every mask bit within its byte, and the set-bit count of each byte.
  always_comb begin : byte_rank
    logic [3:0] run;
    for (int g = 0; g < GROUPS; g++) begin
      run = 4'd0;
      for (int k = 0; k < GROUP_W; k++) begin
        local_next[g*GROUP_W+k] = run[2:0];
        run = run + {3'b0, mask[g*GROUP_W+k]};
      end
      count_next[g] = run;
    end
  end

  always_ff @(posedge clk) begin
    mask_s2  <= mask;
    src_s2   <= src;
    local_s2 <= local_next;
    count_s2 <= count_next;
  end

  // Running offset of each byte: how many mask bits lie below it.
  always_comb begin
    offset_next[0] = 6'd0;
    for (int g = 1; g < GROUPS; g++) begin
      offset_next[g] = offset_next[g-1] + {2'b0, count_s2[g-1]};
    end
  end

  always_ff @(posedge clk) begin
    mask_s3   <= mask_s2;
    src_s3    <= src_s2;
    local_s3  <= local_s2;
    offset_s3 <= offset_next;
  end

  // Each set mask bit takes the source bit at its overall rank.
  for (genvar i = 0; i < WORD_W; i++) begin : g_bit
    logic [CNT_W-1:0] rank;
    assign rank      = offset_s3[i/GROUP_W] + {3'b0, local_s3[i]};
    assign result[i] = mask_s3[i] & src_s3[rank];
  end

endmodule

// ===== hdl/bpms_multiply.sv =====
// Unsigned 64x64 multiplier: 32x32 partial products, middle sum, final add.
// Depends on bpms_pkg.
module bpms_multiply import bpms_pkg::*; (
  input  logic   clk,
  input  word_t  a,
  input  word_t  b,
  output dword_t product
);

  word_t           p00;
  word_t           p01;
  word_t           p10;
  word_t           p11;
  logic [WORD_W:0] mid;
  dword_t          base;

  // Four partial products of the operand halves.
  always_ff @(posedge clk) begin
    p00 <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
    p01 <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[WORD_W-1:HALF_W]);
    p10 <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);
    p11 <= WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[WORD_W-1:HALF_W]);
  end

  // Cross terms summed; outer terms side by side.
  always_ff @(posedge clk) begin
    mid  <= {1'b0, p01} + {1'b0, p10};
    base <= {p11, p00};
  end

  // The cross sum enters the product at bit 32.
  assign product = base + {{(HALF_W-1){1'b0}}, mid, {HALF_W{1'b0}}};

endmodule

// ===== hdl/bmi2_pdep_mulx_shrx_unit.sv =====
// Top level of the PDEP / MULX / SHRX execution unit.
// Depends on bpms_pkg, bpms_deposit and bpms_multiply.
//
// Usage:
//   An operation is transferred in at a rising edge where start is high and
//   busy is low. busy is high only while rst is high, so a new operation can
//   be issued in every cycle. operation selects pdep, mulx or shrx; wide
//   selects 64-bit operands, otherwise both operands are cut to 32 bits and
//   the results are zero-extended.
//   Each operation gives exactly one result, shown on main_result and
//   low_half for one cycle with done high. The throughput is one operation
//   per cycle. An operation passes through four register stages: the input
//   register, the partial products and byte ranks, the cross sum and byte
//   offsets, and the output register behind the final 128-bit add and the
//   deposit select.
//   The receiver cannot stall; results are never held back.
//   A synchronous reset clears the valid bits, so operations in flight are
//   dropped and done stays low until new ones arrive.
module bmi2_pdep_mulx_shrx_unit import bpms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic       wide,
  input  word_t      operand_a,
  input  word_t      operand_b,
  output logic       done,
  output word_t      main_result,
  output word_t      low_half
);

  ctrl_t            ctrl_s1;
  ctrl_t            ctrl_s2;
  ctrl_t            ctrl_s3;
  word_t            a_s1;
  word_t            b_s1;
  word_t            shr_s2;
  word_t            shr_s3;
  logic [CNT_W-1:0] shift_cnt;
  word_t            deposit_res;
  dword_t           product;
  word_t            main_next;
  word_t            low_next;

  assign busy = rst;

  // Input register; narrow operands are cut to 32 bits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s1 <= '0;
    end else begin
      ctrl_s1.valid <= start && !busy;
      ctrl_s1.op    <= operation;
      ctrl_s1.wide  <= wide;
    end
    a_s1 <= wide ? operand_a : {{HALF_W{1'b0}}, operand_a[HALF_W-1:0]};
    b_s1 <= wide ? operand_b : {{HALF_W{1'b0}}, operand_b[HALF_W-1:0]};
  end

  bpms_deposit u_deposit (
    .clk    (clk),
    .mask   (a_s1),
    .src    (b_s1),
    .result (deposit_res)
  );

  bpms_multiply u_multiply (
    .clk     (clk),
    .a       (a_s1),
    .b       (b_s1),
    .product (product)
  );

  // Logical right shift by the count taken modulo the operand size.
  assign shift_cnt = b_s1[CNT_W-1:0] &
                     (ctrl_s1.wide ? SHIFT_MASK_WIDE : SHIFT_MASK_NARROW);

  // Control and shift result follow the datapath units stage by stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_s2 <= '0;
      ctrl_s3 <= '0;
    end else begin
      ctrl_s2 <= ctrl_s1;
      ctrl_s3 <= ctrl_s2;
    end
    shr_s2 <= a_s1 >> shift_cnt;
    shr_s3 <= shr_s2;
  end

  // Result select by operation and operand size.
  always_comb begin
    main_next = '0;
    low_next  = '0;
    unique case (ctrl_s3.op)
      OP_PDEP: main_next = deposit_res;
      OP_MULX: begin
        if (ctrl_s3.wide) begin
          main_next = product[2*WORD_W-1:WORD_W];
          low_next  = product[WORD_W-1:0];
        end else begin
          main_next = {{HALF_W{1'b0}}, product[WORD_W-1:HALF_W]};
          low_next  = {{HALF_W{1'b0}}, product[HALF_W-1:0]};
        end
      end
      OP_SHRX: main_next = shr_s3;
      default: begin
        main_next = '0;
        low_next  = '0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_s3.valid;
    end
    main_result <= main_next;
    low_half    <= low_next;
  end

endmodule

// ===== hdl/bpms_checker.sv =====
// Port-level checks of the execution unit, attached to the top level by bind.
// Depends on bpms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpms_checker import bpms_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       wide,
  input logic       done,
  input word_t      main_result,
  input word_t      low_half
);

  // The unit takes new operations whenever it is out of reset.
  `BPMS_ASSERT_ALWAYS(a_never_busy, clk, !rst |-> !busy, "busy high out of reset")

  // Every transfer in gives a result with done high at the output.
  `BPMS_ASSERT(a_result_follows, clk, rst, (start && !busy) |-> ##4 done,
    "result missing four cycles after transfer")

  // No result appears without a matching transfer in.
  `BPMS_ASSERT(a_no_spurious, clk, rst, done |-> $past(start && !busy, 4),
    "result without a transfer in")

  // Only mulx fills the low half.
  `BPMS_ASSERT(a_low_half_zero, clk, rst,
    (done && $past(operation, 4) != OP_MULX) |-> (low_half == '0),
    "low half nonzero for an operation other than mulx")

  // Narrow operations give zero-extended results.
  `BPMS_ASSERT(a_narrow_extend, clk, rst,
    (done && !$past(wide, 4)) |->
      (main_result[WORD_W-1:HALF_W] == '0 && low_half[WORD_W-1:HALF_W] == '0),
    "narrow result not zero-extended")

endmodule

bind bmi2_pdep_mulx_shrx_unit bpms_checker u_checker (.*);

// ===== sim/tb_bmi2_pdep_mulx_shrx_unit.sv =====
// Self-checking testbench for the PDEP / MULX / SHRX execution unit.
// Depends on bpms_pkg and bmi2_pdep_mulx_shrx_unit; a small class predicts and checks
// every result, and plain tasks drive operations with random idle bursts.
module tb_bmi2_pdep_mulx_shrx_unit import bpms_pkg::*; ();

  // Operation code 3 has no meaning; the unit must still answer with zeros.
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int LATENCY      = 4;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    word_t main_w;
    word_t low_w;
  } bmi_result_t;

  // Predicts the result of each transferred operation and checks the results in order.
  class bmi_scoreboard;
    bmi_result_t pending_q[$];
    int mismatches = 0;
    int checked    = 0;

    // Scatter the low source bits into the set mask positions, lowest first.
    function word_t deposit(word_t mask, word_t src);
      word_t res;
      int k;
      res = '0;
      k = 0;
      for (int pos = 0; pos < WORD_W; pos++) begin
        if (mask[pos]) begin
          res[pos] = src[k];
          k++;
        end
      end
      return res;
    endfunction

    // Work out the result of one transferred operation and queue it.
    function void note(logic [1:0] op, logic wide, word_t a, word_t b);
      bmi_result_t r;
      dword_t prod;
      logic [CNT_W-1:0] cnt;
      r.main_w = '0;
      r.low_w  = '0;
      if (!wide) begin
        a[WORD_W-1:HALF_W] = '0;
        b[WORD_W-1:HALF_W] = '0;
      end
      case (op)
        OP_PDEP: begin
          r.main_w = deposit(a, b);
        end
        OP_MULX: begin
          prod = dword_t'(a) * dword_t'(b);
          if (wide) begin
            r.main_w = prod[2*WORD_W-1:WORD_W];
            r.low_w  = prod[WORD_W-1:0];
          end else begin
            r.main_w = word_t'(prod[WORD_W-1:HALF_W]);
            r.low_w  = word_t'(prod[HALF_W-1:0]);
          end
        end
        OP_SHRX: begin
          cnt = b[CNT_W-1:0] & (wide ? SHIFT_MASK_WIDE : SHIFT_MASK_NARROW);
          r.main_w = a >> cnt;
        end
        default: begin
        end
      endcase
      pending_q.push_back(r);
    endfunction

    // Compare one result with the oldest prediction.
    function void check(word_t main_v, word_t low_v);
      bmi_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: main_result %h low_half %h", $time, main_v, low_v);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (main_v !== e.main_w) begin
        $display("%0t: main_result mismatch: expected %h, actual %h", $time, e.main_w, main_v);
        mismatches++;
      end
      if (low_v !== e.low_w) begin
        $display("%0t: low_half mismatch: expected %h, actual %h", $time, e.low_w, low_v);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic [1:0] operation = OP_PDEP;
  logic       wide      = 1'b0;
  word_t      operand_a = '0;
  word_t      operand_b = '0;
  logic       busy;
  logic       done;
  word_t      main_result;
  word_t      low_half;

  bmi_scoreboard sb = new();
  int cycles = 0;
  int op_count[4] = '{0, 0, 0, 0};
  int narrow_count = 0;

  bmi2_pdep_mulx_shrx_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .wide       (wide),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .done       (done),
    .main_result(main_result),
    .low_half   (low_half)
  );

  always #6 clk = ~clk;

  // Note every input transfer and check every result at the edge that takes it.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        sb.note(operation, wide, operand_a, operand_b);
        op_count[operation]++;
        if (!wide) narrow_count++;
      end
      if (done) sb.check(main_result, low_half);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one operation and hold it until the unit takes the transfer.
  task automatic issue_op(input logic [1:0] op, input logic w, input word_t a,
                          input word_t b);
    start     <= 1'b1;
    operation <= op;
    wide      <= w;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every predicted result has come back.
  task automatic wait_results_in();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 7))
      0: w = '1;
      1: w = word_t'(1) << $urandom_range(0, WORD_W - 1);
      2: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: w = {$urandom, $urandom} | {$urandom, $urandom};
      4: w = word_t'($urandom_range(0, 255));
      5: w = {$urandom, $urandom} >> $urandom_range(0, WORD_W - 1);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  initial begin
    logic [1:0] op;
    int pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, every operation, both sizes, shift count wrap.
    issue_op(OP_PDEP, 1'b1, '1, 64'h0123_4567_89AB_CDEF);
    issue_op(OP_PDEP, 1'b1, '0, '1);
    issue_op(OP_PDEP, 1'b1, '1, '0);
    issue_op(OP_PDEP, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, '1);
    issue_op(OP_PDEP, 1'b1, 64'h8000_0000_0000_0001, 64'h3);
    issue_op(OP_PDEP, 1'b0, '1, '1);
    issue_op(OP_PDEP, 1'b0, 64'hFFFF_0000_F0F0_F0F0, 64'h5A5A_5A5A_0000_A5A5);
    issue_op(OP_MULX, 1'b1, '1, '1);
    issue_op(OP_MULX, 1'b1, '0, '1);
    issue_op(OP_MULX, 1'b1, 64'h1, 64'hFEDC_BA98_7654_3210);
    issue_op(OP_MULX, 1'b1, 64'h8000_0000_0000_0000, 64'h2);
    issue_op(OP_MULX, 1'b0, '1, '1);
    issue_op(OP_MULX, 1'b0, 64'hDEAD_BEEF_0000_0002, 64'h1_8000_0000);
    issue_op(OP_SHRX, 1'b1, '1, 64'h0);
    issue_op(OP_SHRX, 1'b1, '1, 64'h3F);
    issue_op(OP_SHRX, 1'b1, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC1);
    issue_op(OP_SHRX, 1'b0, '1, 64'h1F);
    issue_op(OP_SHRX, 1'b0, 64'hFFFF_FFFF_8000_0001, 64'h20);
    issue_op(OP_SHRX, 1'b0, 64'h1234_5678_8765_4321, '1);
    issue_op(OP_UNDEF, 1'b1, '1, '1);
    issue_op(OP_UNDEF, 1'b0, '1, '1);
    wait_results_in();

    // Random part; idle bursts stop for the last fifth of the items.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS * 4 / 5 && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 12));
      if (i == RANDOM_ITEMS / 2) wait_results_in();
      pick = $urandom_range(0, 15);
      op = (pick == 0) ? OP_UNDEF : 2'((pick - 1) % 3);
      issue_op(op, 1'($urandom_range(0, 1)), rand_word(), rand_word());
    end

    // Let the pipeline empty, then give stray results time to show up.
    wait_results_in();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d pdep, %0d mulx, %0d shrx and %0d undefined operations, %0d narrow.",
             op_count[OP_PDEP], op_count[OP_MULX], op_count[OP_SHRX], op_count[OP_UNDEF],
             narrow_count);
    $display("Checked %0d results with %0d mismatches and %0d still outstanding.",
             sb.checked, sb.mismatches, sb.pending_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
